@@ rtl/spq_pkg.sv @@
package spq_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned OccWidth   = 4;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Operation broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctl_t;

endpackage

@@ rtl/spq_cell.sv @@
module spq_cell
  import spq_pkg::*;
(
  input  logic                         clk_i,
  input  spq_ctl_t                     ctl_i,
  input  logic                         live_i,
  input  logic signed [ValueWidth-1:0] value_i,
  input  logic signed [ValueWidth-1:0] left_value_i,
  input  logic                         left_ge_i,
  input  logic signed [ValueWidth-1:0] right_value_i,
  output logic                         ge_o,
  output logic signed [ValueWidth-1:0] value_o
);

  logic signed [ValueWidth-1:0] value_q, value_d;

  // An empty slot always takes the new value if nothing to its left does.
  assign ge_o = !live_i || (value_i >= value_q);

  always_comb begin
    value_d = value_q;
    if (ctl_i.ins) begin
      if (left_ge_i) begin
        value_d = left_value_i;
      end else if (ge_o) begin
        value_d = value_i;
      end
    end else if (ctl_i.rem) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Channel  | Handshake                  | Payload
// request  | in_valid_i / in_ready_o    | req_type_i, value_i
// result   | out_valid_o / out_ready_i  | status_o, top_value_o, occupancy_o
//
// Every request beat yields exactly one result beat, in the cycle after acceptance.
// A new request is taken every cycle while the result register is empty or being
// drained; the cell chain compares and shifts combinationally, so it never holds it.
// A stalled result holds the request side only if the result register stays full.
// Reset (rst_ni low, asynchronous) empties the queue and the result register; the
// stored values are not cleared since slots at or beyond the count never reach a result.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic signed [ValueWidth-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic signed [ValueWidth-1:0] top_value_o,
  output logic [OccWidth-1:0]          occupancy_o
);

  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

  logic [CntWidth-1:0] count_q, count_d;

  logic                         out_valid_q, out_valid_d;
  logic [1:0]                   status_q, status_d;
  logic signed [ValueWidth-1:0] top_q, top_d;
  logic [OccWidth-1:0]          occ_q, occ_d;

  logic     accept;
  logic     full;
  logic     empty;
  spq_ctl_t ctl;

  logic signed [ValueWidth-1:0] cell_value [DEPTH];
  logic                         cell_ge    [DEPTH];

  // The result register frees up as soon as its beat is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntFull);
  assign empty      = (count_q == '0);

  // Slot 0 is the head; the chain is kept in non-increasing order over live slots.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                         live;
    logic signed [ValueWidth-1:0] left_value;
    logic                         left_ge;
    logic signed [ValueWidth-1:0] right_value;

    assign live = (count_q > CntWidth'(g));

    if (g == 0) begin : g_head
      assign left_value = cell_value[0];
      assign left_ge    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[g-1];
      assign left_ge    = cell_ge[g-1];
    end

    // The tail slot has no right neighbor; after a remove it falls out of range.
    if (g == DEPTH - 1) begin : g_tail
      assign right_value = cell_value[g];
    end else begin : g_inner
      assign right_value = cell_value[g+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .live_i        (live),
      .value_i       (value_i),
      .left_value_i  (left_value),
      .left_ge_i     (left_ge),
      .right_value_i (right_value),
      .ge_o          (cell_ge[g]),
      .value_o       (cell_value[g])
    );
  end

  // Decode the request, update the count and build the result beat.
  always_comb begin
    ctl         = '0;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    top_d       = top_q;
    occ_d       = occ_q;

    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      top_d       = '0;
      case (req_type_i)
        REQ_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl.ins = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        REQ_REMOVE, REQ_PEEK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            top_d = cell_value[0];
            if (req_type_i == REQ_REMOVE) begin
              ctl.rem = 1'b1;
              count_d = count_q - 1'b1;
            end
          end
        end
        default: begin
          // Unused request code leaves the queue alone and reports OK.
        end
      endcase
      occ_d = OccWidth'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    top_q    <= top_d;
    occ_q    <= occ_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign top_value_o = top_q;
  assign occupancy_o = occ_q;

endmodule

@@ rtl/spq_checker.sv @@
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   status_o,
  input logic signed [ValueWidth-1:0] top_value_o,
  input logic [OccWidth-1:0]          occupancy_o
);

  localparam logic [OccWidth-1:0] OccFull = OccWidth'(DEPTH);

  // A result beat waiting for the sink keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(top_value_o) && $stable(occupancy_o))
    else $error("result beat changed while stalled");

  // A refused insert only happens with every slot in use.
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> occupancy_o == OccFull && top_value_o == '0)
    else $error("full status with wrong occupancy or value");

  // An empty status reports nothing stored and a zero value.
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> occupancy_o == '0 && top_value_o == '0)
    else $error("empty status with stored entries or nonzero value");

  // Every accepted request produces a result beat in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request produced no result");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .top_value_o (top_value_o),
  .occupancy_o (occupancy_o)
);

@@ test/tb.sv @@
module tb;
  import spq_pkg::*;

  localparam int unsigned QDEPTH = 8;
  // Request code with no operation behind it; the block must ignore it.
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int unsigned RandomItems = 1570;

  typedef struct {
    logic [1:0]                   status;
    logic signed [ValueWidth-1:0] top;
    logic [OccWidth-1:0]          occ;
  } queue_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [1:0]                   req_type_i;
  logic signed [ValueWidth-1:0] value_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [1:0]                   status_o;
  logic signed [ValueWidth-1:0] top_value_o;
  logic [OccWidth-1:0]          occupancy_o;

  // Shadow copy of the sorted store, largest value in slot 0.
  logic signed [ValueWidth-1:0] shadow_vals [QDEPTH+1];
  int                           shadow_count;

  // Results that the shadow store predicts, oldest first.
  queue_result_t                awaited_results[$];
  int                           mismatches;

  // Idling switches for the request and result sides.
  bit                           req_gaps_on;
  bit                           result_stalls_on;

  sorted_priority_queue #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .top_value_o(top_value_o),
    .occupancy_o(occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("** sorted_priority_queue: FAILED **");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values lean on a narrow band so that ties and near ties are common, with
  // the two extremes and fully random words mixed in.
  function automatic logic signed [ValueWidth-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $signed($urandom_range(0, 15)) - 8;
    if (r == 4) return 32'sh7fff_ffff;
    if (r == 5) return 32'sh8000_0000;
    return $urandom();
  endfunction

  // Applies one accepted request to the shadow store and queues the result
  // the block must give for it.
  task automatic apply_to_shadow(input logic [1:0] req,
                                 input logic signed [ValueWidth-1:0] val);
    queue_result_t res;
    int            i;
    res.status = ST_OK;
    res.top    = '0;
    case (req)
      REQ_INSERT: begin
        if (shadow_count >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          // Walk up from the tail, moving down every entry the new value
          // does not fall below; ties therefore leave newest first.
          i = shadow_count;
          while (i > 0 && val >= shadow_vals[i-1]) begin
            shadow_vals[i] = shadow_vals[i-1];
            i--;
          end
          shadow_vals[i] = val;
          shadow_count++;
        end
      end
      REQ_REMOVE, REQ_PEEK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.top = shadow_vals[0];
          if (req == REQ_REMOVE) begin
            for (i = 1; i < shadow_count; i++) shadow_vals[i-1] = shadow_vals[i];
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    res.occ = OccWidth'(shadow_count);
    awaited_results.push_back(res);
  endtask

  // Drives one request beat and waits for it to be taken. Valid is raised at
  // a falling edge whatever ready says, and the beat counts at the first
  // rising edge with ready high.
  task automatic send_request(input logic [1:0] req,
                              input logic signed [ValueWidth-1:0] val);
    int unsigned gap;
    gap = req_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_to_shadow(req, val);
  endtask

  // Result side: ready is lowered for random stretches.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned stall;
      stall = result_stalls_on ? pick_gap() : 0;
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
    end
  end

  // Every result beat is held against the oldest awaited result.
  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: status %0d top %0d occupancy %0d",
               status_o, top_value_o, occupancy_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (top_value_o !== want.top) begin
          $error("top_value: expected %0d, got %0d", want.top, top_value_o);
          mismatches++;
        end
        if (occupancy_o !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, occupancy_o);
          mismatches++;
        end
      end
    end
  end

  // Empty-store requests, the value extremes, ties, a full store, the unused
  // code in both corners, and a complete drain.
  task automatic test_corner_requests();
    send_request(REQ_PEEK, 32'sd0);
    send_request(REQ_REMOVE, 32'sh1234_5678);
    send_request(ReqUnused, 32'shffff_ffff);
    send_request(REQ_INSERT, 32'sh7fff_ffff);
    send_request(REQ_INSERT, 32'sh8000_0000);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, -32'sd1);
    send_request(REQ_INSERT, 32'sd1);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, 32'sh7fff_ffff);
    send_request(REQ_INSERT, 32'sh8000_0000);
    send_request(REQ_INSERT, 32'sd5);
    send_request(ReqUnused, 32'sd0);
    send_request(REQ_PEEK, 32'sh5555_5555);
    repeat (QDEPTH) send_request(REQ_REMOVE, 32'shaaaa_aaaa);
    send_request(REQ_REMOVE, 32'sd0);
    send_request(REQ_PEEK, 32'sd0);
  endtask

  // Fill to full and then drain with mostly removes and some peeks, over and
  // over, so the full boundary is met every round and the empty one at times.
  task automatic test_fill_and_drain(input int unsigned rounds);
    repeat (rounds) begin
      repeat (QDEPTH + $urandom_range(0, 2)) send_request(REQ_INSERT, pick_value());
      if ($urandom_range(0, 1)) send_request(REQ_PEEK, pick_value());
      repeat (QDEPTH + $urandom_range(0, 2)) begin
        send_request($urandom_range(0, 3) == 0 ? REQ_PEEK : REQ_REMOVE, pick_value());
      end
    end
  endtask

  // Random mix whose insert share changes every batch, so the store drifts
  // between empty and full rather than hovering in the middle.
  task automatic test_random_mix(input int unsigned count);
    int unsigned insert_pct;
    int unsigned r;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      insert_pct = $urandom_range(20, 80);
      repeat (20) begin
        r = $urandom_range(0, 99);
        if (r < insert_pct) send_request(REQ_INSERT, pick_value());
        else if (r < insert_pct + (100 - insert_pct) * 2 / 3)
          send_request(REQ_REMOVE, pick_value());
        else if (r < 98) send_request(REQ_PEEK, pick_value());
        else send_request(ReqUnused, pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned guard;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    req_type_i       = REQ_INSERT;
    value_i          = '0;
    shadow_count     = 0;
    mismatches       = 0;
    req_gaps_on      = 1'b1;
    result_stalls_on = 1'b1;
    foreach (shadow_vals[k]) shadow_vals[k] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_corner_requests();
    test_fill_and_drain(20);
    // A stretch at full rate on both sides.
    req_gaps_on      = 1'b0;
    result_stalls_on = 1'b0;
    test_random_mix(300);
    // Back-pressure only, then source gaps only, then both.
    result_stalls_on = 1'b1;
    test_random_mix(300);
    req_gaps_on      = 1'b1;
    result_stalls_on = 1'b0;
    test_random_mix(200);
    result_stalls_on = 1'b1;
    test_random_mix(RandomItems - 800 - 20 * 2 * (QDEPTH + 2));
    test_fill_and_drain(5);

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    guard = 0;
    while (awaited_results.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      mismatches++;
    end
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
